@@ design/ssds_pkg.sv @@
// ----------------------------------------------------------------------------
// ssds_pkg: shared types and constants for the decimal seven-segment scanner
// Digit widths, the segment table and the BCD digit count.
// ----------------------------------------------------------------------------
package ssds_pkg;

  localparam int BIN_W    = 16;  // binary input width
  localparam int DIGIT_W  = 4;   // one BCD digit
  localparam int N_DIGITS = 5;   // enough for 65535
  localparam int BCD_W    = DIGIT_W * N_DIGITS;
  localparam int POS_W    = 3;
  localparam int SEG_W    = 7;
  localparam int CNT_W    = 4;   // counts BIN_W shift steps

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [SEG_W-1:0]   seg_t;
  typedef logic [POS_W-1:0]   pos_t;

  // Segments a..g in bits 0..6, active high
  function automatic seg_t seg_lookup(input digit_t d);
    seg_t s;
    case (d)
      4'd0:    s = 7'h3f;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5b;
      4'd3:    s = 7'h4f;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6d;
      4'd6:    s = 7'h7d;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7f;
      4'd9:    s = 7'h6f;
      default: s = 7'h3f;
    endcase
    return s;
  endfunction

endpackage

@@ design/seven_segment_decimal_scan_core.sv @@
// ----------------------------------------------------------------------------
// seven_segment_decimal_scan_core: binary to decimal seven-segment scanner
// Converts a 16-bit number to BCD one bit per cycle (shift and add-3), then
// emits one transaction per significant digit, most significant first.
// ----------------------------------------------------------------------------
//  Channel | Ports                                        | Direction
//  --------+----------------------------------------------+----------
//  in      | in_valid, in_ready, in_value                 | sink
//  out     | out_valid, out_ready, out_digit_position,    | source
//          | out_segments, out_last                       |
//  cfg     | cfg_we, cfg_common_anode                     | sink
//
//  An item is loaded, then takes 16 shift steps of the BCD converter and
//  a step to find the leading digit, then emits n digits (1..NUM_DISPLAYS),
//  one per cycle while the output register drains and is not stalled.
//  The next item is taken once the last digit sits in the output register.
//  Reset (rst_n low, synchronous) clears control state and common_anode.
//  A stalled output holds the scanner in its emit step.
// ----------------------------------------------------------------------------
module seven_segment_decimal_scan_core #(
  parameter int NUM_DISPLAYS = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic                      cfg_common_anode,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [ssds_pkg::BIN_W-1:0] in_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [ssds_pkg::POS_W-1:0] out_digit_position,
  output logic [ssds_pkg::SEG_W-1:0] out_segments,
  output logic                      out_last
);
  import ssds_pkg::*;

  localparam pos_t TOP_POS = POS_W'(NUM_DISPLAYS - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_FIND, ST_EMIT} state_t;

  state_t               state_r, state_nxt;
  logic [BIN_W-1:0]     bin_r, bin_nxt;
  logic [BCD_W-1:0]     bcd_r, bcd_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  pos_t                 pos_r, pos_nxt;
  logic                 anode_r;
  logic                 out_valid_r, out_valid_nxt;
  pos_t                 out_pos_r, out_pos_nxt;
  seg_t                 out_seg_r, out_seg_nxt;
  logic                 out_last_r, out_last_nxt;

  logic [BCD_W-1:0]     bcd_adj;
  digit_t               cur_digit;
  pos_t                 msd;
  logic                 out_free;

  // add-3 correction on every digit before the shift
  always_comb begin
    for (int i = 0; i < N_DIGITS; i++) begin
      if (bcd_r[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5))
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_r[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
      else
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_r[i*DIGIT_W +: DIGIT_W];
    end
  end

  // most significant non-zero digit, units if all zero
  always_comb begin
    msd = '0;
    for (int i = 1; i < N_DIGITS; i++) begin
      if (bcd_r[i*DIGIT_W +: DIGIT_W] != '0) msd = POS_W'(i);
    end
  end

  always_comb begin
    cur_digit = '0;
    for (int i = 0; i < N_DIGITS; i++) begin
      if (pos_r == POS_W'(i)) cur_digit = bcd_r[i*DIGIT_W +: DIGIT_W];
    end
  end

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    bin_nxt       = bin_r;
    bcd_nxt       = bcd_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_pos_nxt   = out_pos_r;
    out_seg_nxt   = out_seg_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          bin_nxt   = in_value;
          bcd_nxt   = '0;
          cnt_nxt   = CNT_W'(BIN_W - 1);
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[BIN_W-1]};
        bin_nxt = {bin_r[BIN_W-2:0], 1'b0};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) state_nxt = ST_FIND;
      end
      ST_FIND: begin
        // digits beyond the last display are dropped
        pos_nxt   = (msd > TOP_POS) ? TOP_POS : msd;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = pos_r;
          out_seg_nxt   = seg_lookup(cur_digit) ^ {SEG_W{anode_r}};
          out_last_nxt  = (pos_r == '0);
          if (pos_r == '0) state_nxt = ST_IDLE;
          else pos_nxt = pos_r - POS_W'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    bin_r      <= bin_nxt;
    bcd_r      <= bcd_nxt;
    cnt_r      <= cnt_nxt;
    pos_r      <= pos_nxt;
    out_pos_r  <= out_pos_nxt;
    out_seg_r  <= out_seg_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anode_r <= 1'b0;
    end else if (cfg_we) begin
      anode_r <= cfg_common_anode;
    end
  end

  assign in_ready           = (state_r == ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_digit_position = out_pos_r;
  assign out_segments       = out_seg_r;
  assign out_last           = out_last_r;

  // last transaction of a number is always the units digit
  a_last_units: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (out_digit_position == '0))
    else $error("last flag on a non-units digit");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_digit_position <= TOP_POS))
    else $error("digit position beyond the displays");

  a_start_conv: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_CONV && cnt_r == CNT_W'(BIN_W - 1)))
    else $error("conversion did not start after accept");

  a_bcd_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIND) |->
      (bcd_r[3:0] <= 4'd9 && bcd_r[7:4] <= 4'd9 && bcd_r[11:8] <= 4'd9 &&
       bcd_r[15:12] <= 4'd9 && bcd_r[19:16] <= 4'd9))
    else $error("invalid BCD digit after conversion");

  a_emit_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (pos_r <= TOP_POS))
    else $error("scan position out of range");

endmodule
